### hdl/ntft_pkg.sv
// ============================================================================
// Note-to-frequency tuning table package
// Shared widths, function codes and the elaboration-time functions that build
// the equal-temperament reset values and the pitch fraction factor table.
// ============================================================================
`default_nettype none

package ntft_pkg;

    localparam int C_TABLE_DEPTH     = 128;
    localparam int C_PITCH_FRAC_BITS = 8;
    localparam int C_PITCH_W         = 16;
    localparam int C_ENTRY_INDEX_W   = 7;
    localparam int C_HZ_W            = 32;
    localparam int C_FACTOR_W        = 17;
    localparam int C_FACTOR_FRAC     = 16;

    localparam logic C_FUNC_WRITE  = 1'b0;
    localparam logic C_FUNC_LOOKUP = 1'b1;

    localparam logic [63:0] C_ONE_Q62 = 64'd1 << 62;

    // Exact (a * b) >> 62 on a full-width product.
    function automatic logic [63:0] f_mul_q62(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[125:62];
    endfunction

    // ln 2 in Q62 as the series sum of 2^-k / k.
    function automatic logic [63:0] f_ln2_q62();
        logic [63:0] s;
        s = '0;
        for (int k = 1; k < 62; k++) begin
            s = s + ((C_ONE_Q62 >> k) / 64'(k));
        end
        return s;
    endfunction

    // 2^(num / (12 * 2^fb)) in Q62 for num below the denominator.
    function automatic logic [63:0] f_exp2_q62(logic [63:0] num, int fb);
        logic [63:0] l;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        l    = f_ln2_q62();
        den  = 64'd12 << fb;
        q    = (l / 64'd12) >> fb;
        r    = l - q * den;
        y    = q * num + (((r * num) / 64'd12) >> fb);
        term = C_ONE_Q62;
        sum  = C_ONE_Q62;
        for (int k = 1; k < 40; k++) begin
            term = f_mul_q62(term, y) / 64'(k);
            sum  = sum + term;
        end
        return sum;
    endfunction

    // Equal-temperament entry for note n in Q16.16 Hz, note 69 at 440 Hz.
    function automatic logic [C_HZ_W-1:0] f_reset_hz(int n);
        int          oct;
        int          deg;
        int          sh;
        logic [63:0] m;
        logic [63:0] prod;
        logic [63:0] v;
        oct  = (n + 3) / 12;
        deg  = (n + 3) % 12;
        m    = (f_exp2_q62(64'(deg), 0) + 64'd512) >> 10;
        prod = 64'd440 * m;
        sh   = 42 - oct;
        v    = (prod + (64'd1 << (sh - 1))) >> sh;
        return (v > 64'hFFFF_FFFF) ? {C_HZ_W{1'b1}} : v[C_HZ_W-1:0];
    endfunction

    // Q1.16 factor 2^(f / (12 * 2^fb)) for a fraction f of a semitone.
    function automatic logic [C_FACTOR_W-1:0] f_factor_q16(int f, int fb);
        logic [63:0] den;
        logic [63:0] e;
        den = 64'd12 << fb;
        if (f >= 0) begin
            e = f_exp2_q62(64'(f), fb);
            e = (e + (64'd1 << 45)) >> 46;
        end else begin
            e = f_exp2_q62(den - 64'(-f), fb);
            e = (e + (64'd1 << 46)) >> 47;
        end
        return e[C_FACTOR_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/ntft_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module ntft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/ntft_table.sv
// ============================================================================
// Note frequency table
// Holds the note entries in RAM with one valid bit per entry; an entry never
// written since reset reads as its equal-temperament value.
// ============================================================================
`default_nettype none

module ntft_table
    import ntft_pkg::*;
#(
    parameter int TABLE_DEPTH = C_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_waddr,
    input  logic [C_HZ_W-1:0]              i_wdata,
    input  logic                           i_rd,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_raddr,
    output logic [C_HZ_W-1:0]              o_entry
);

    typedef logic [C_HZ_W-1:0] t_rst_tbl [TABLE_DEPTH];

    function automatic t_rst_tbl f_build_rst();
        t_rst_tbl t;
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            t[n] = f_reset_hz(n);
        end
        return t;
    endfunction

    localparam t_rst_tbl C_RST_HZ = f_build_rst();

    logic [TABLE_DEPTH-1:0] r_written;
    logic                   r_sel_ram;
    logic [C_HZ_W-1:0]      r_rst_hz;
    logic [C_HZ_W-1:0]      ram_q;

    ntft_ram #(
        .WIDTH (C_HZ_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_rd),
        .i_raddr (i_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr) begin
            r_written[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_sel_ram <= r_written[i_raddr];
            r_rst_hz  <= C_RST_HZ[i_raddr];
        end
    end

    assign o_entry = r_sel_ram ? ram_q : r_rst_hz;

endmodule

`default_nettype wire

### hdl/ntft_factor_rom.sv
// ============================================================================
// Pitch fraction factor ROM
// Registered lookup of the Q1.16 factor 2^(frac/12) over the fraction range
// from minus half a semitone to one step under a whole semitone.
// ============================================================================
`default_nettype none

module ntft_factor_rom
    import ntft_pkg::*;
#(
    parameter int PITCH_FRAC_BITS = C_PITCH_FRAC_BITS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rd,
    input  logic [$clog2(3 << (PITCH_FRAC_BITS - 1))-1:0] i_idx,
    output logic [C_FACTOR_W-1:0]                         o_factor
);

    localparam int STEP  = 1 << PITCH_FRAC_BITS;
    localparam int HALF  = STEP / 2;
    localparam int DEPTH = STEP + HALF;

    typedef logic [C_FACTOR_W-1:0] t_factor_tbl [DEPTH];

    function automatic t_factor_tbl f_build_factor();
        t_factor_tbl t;
        for (int i = 0; i < DEPTH; i++) begin
            t[i] = f_factor_q16(i - HALF, PITCH_FRAC_BITS);
        end
        return t;
    endfunction

    localparam t_factor_tbl C_FACTOR = f_build_factor();

    logic [C_FACTOR_W-1:0] r_factor;

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_factor <= C_FACTOR[i_idx];
        end
    end

    assign o_factor = r_factor;

endmodule

`default_nettype wire

### hdl/note_to_frequency_tuning_table.sv
// ============================================================================
// Note-to-frequency tuning table
// Writable table of note frequencies with fractional-pitch lookup.
//
//   Channel  Handshake                  Payload
//   input    i_in_valid / o_in_ready    i_func, i_pitch, i_entry_index, i_entry_hz
//   output   o_out_valid / i_out_ready  o_freq_hz
//
// One item is accepted per cycle while o_in_ready is high, write or lookup alike.
// A lookup's result passes through table read and factor ROM read, then the multiply,
// then rounding and saturation into the output register.
// A write produces no result and updates the table at its acceptance edge.
// Reset clears all per-entry valid bits together; there is no clearing pass.
// An output stall backs up through the pipeline, and empty stages keep filling.
// ============================================================================
`default_nettype none

module note_to_frequency_tuning_table
    import ntft_pkg::*;
#(
    parameter int TABLE_DEPTH     = C_TABLE_DEPTH,
    parameter int PITCH_FRAC_BITS = C_PITCH_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_func,
    input  logic signed [C_PITCH_W-1:0] i_pitch,
    input  logic [C_ENTRY_INDEX_W-1:0]  i_entry_index,
    input  logic [C_HZ_W-1:0]           i_entry_hz,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [C_HZ_W-1:0]           o_freq_hz
);

    localparam int STEP   = 1 << PITCH_FRAC_BITS;
    localparam int HALF   = STEP / 2;
    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int NW     = C_PITCH_W - PITCH_FRAC_BITS;
    localparam int IW     = $clog2(STEP + HALF);
    localparam int FRAC_W = 24;
    localparam int PW     = C_HZ_W + C_FACTOR_W;

    localparam logic signed [FRAC_W-1:0] FRAC_MIN  = FRAC_W'(-HALF);
    localparam logic signed [FRAC_W-1:0] FRAC_MAX  = FRAC_W'(STEP - 1);
    localparam logic signed [FRAC_W-1:0] FRAC_HALF = FRAC_W'(HALF);
    localparam logic [PW-1:0]            ROUND_ADD = PW'(1) << (C_FACTOR_FRAC - 1);

    logic                     in_acc;
    logic                     rd;
    logic                     wr;
    logic                     s1_move;
    logic                     s2_move;
    logic                     s3_move;
    logic [C_PITCH_W-1:0]     rnd;
    logic [NW-1:0]            note_big;
    logic [AW-1:0]            note;
    logic signed [FRAC_W-1:0] pitch_x;
    logic signed [FRAC_W-1:0] note_scaled;
    logic signed [FRAC_W-1:0] frac;
    logic signed [FRAC_W-1:0] frac_c;
    logic signed [FRAC_W-1:0] idx_sum;
    logic [IW-1:0]            rom_idx;
    logic [C_HZ_W-1:0]        entry;
    logic [C_FACTOR_W-1:0]    factor;
    logic [PW-1:0]            n_prod;
    logic [PW-1:0]            round_sum;
    logic [PW-C_FACTOR_FRAC-1:0] scaled;
    logic [C_HZ_W-1:0]        n_freq;

    logic                     r_s1_vld;
    logic                     r_s2_vld;
    logic [PW-1:0]            r_s2_prod;
    logic                     r_out_vld;
    logic [C_HZ_W-1:0]        r_out_freq;

    assign s3_move    = !r_out_vld || i_out_ready;
    assign s2_move    = !r_s2_vld || s3_move;
    assign s1_move    = !r_s1_vld || s2_move;
    assign o_in_ready = s1_move;
    assign in_acc     = i_in_valid && s1_move;
    assign rd         = in_acc && (i_func == C_FUNC_LOOKUP);
    assign wr         = in_acc && (i_func == C_FUNC_WRITE) &&
                        (32'(i_entry_index) < 32'(TABLE_DEPTH));

    // Nearest note with halves away from zero; negative pitches clamp to note 0, notes past the table to the last.
    always_comb begin
        rnd      = {1'b0, i_pitch[C_PITCH_W-2:0]} + C_PITCH_W'(HALF);
        note_big = rnd[C_PITCH_W-1:PITCH_FRAC_BITS];
        if (i_pitch[C_PITCH_W-1]) begin
            note = '0;
        end else if (32'(note_big) > 32'(TABLE_DEPTH - 1)) begin
            note = AW'(TABLE_DEPTH - 1);
        end else begin
            note = AW'(note_big);
        end
        pitch_x     = FRAC_W'(i_pitch);
        note_scaled = FRAC_W'({note, {PITCH_FRAC_BITS{1'b0}}});
        frac        = pitch_x - note_scaled;
        if (frac < FRAC_MIN) begin
            frac_c = FRAC_MIN;
        end else if (frac > FRAC_MAX) begin
            frac_c = FRAC_MAX;
        end else begin
            frac_c = frac;
        end
        idx_sum = frac_c + FRAC_HALF;
        rom_idx = idx_sum[IW-1:0];
    end

    ntft_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (i_entry_hz),
        .i_rd    (rd),
        .i_raddr (note),
        .o_entry (entry)
    );

    ntft_factor_rom #(
        .PITCH_FRAC_BITS (PITCH_FRAC_BITS)
    ) u_factor_rom (
        .i_clk    (i_clk),
        .i_rd     (rd),
        .i_idx    (rom_idx),
        .o_factor (factor)
    );

    // A zero fraction selects the unity factor, so the entry passes through exactly.
    assign n_prod    = PW'(entry) * PW'(factor);
    assign round_sum = r_s2_prod + ROUND_ADD;
    assign scaled    = round_sum[PW-1:C_FACTOR_FRAC];
    assign n_freq    = (scaled[PW-C_FACTOR_FRAC-1:C_HZ_W] != '0) ?
                       {C_HZ_W{1'b1}} : scaled[C_HZ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_move) begin
                r_s1_vld <= rd;
            end
            if (s2_move) begin
                r_s2_vld <= r_s1_vld;
            end
            if (s3_move) begin
                r_out_vld <= r_s2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move && r_s1_vld) begin
            r_s2_prod <= n_prod;
        end
        if (s3_move && r_s2_vld) begin
            r_out_freq <= n_freq;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_freq_hz   = r_out_freq;

endmodule

`default_nettype wire

### hdl/ntft_checker.sv
// ============================================================================
// Tuning table port checker
// Watches the top-level ports for pipeline latency, stall and reset behavior.
// ============================================================================
`default_nettype none

module ntft_port_checker
    import ntft_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              i_func,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [C_HZ_W-1:0] o_freq_hz
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_freq_hz))
        else $error("Stalled output item changed or vanished.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_func == C_FUNC_LOOKUP) ##1 i_out_ready
        ##1 i_out_ready |=> o_out_valid)
        else $error("Lookup item did not reach the output in three cycles.");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("Input held off without an output stall.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid right after reset.");

endmodule

bind note_to_frequency_tuning_table ntft_port_checker u_ntft_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_func      (i_func),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_freq_hz   (o_freq_hz)
);

`default_nettype wire

### verif/ntft_checker.sv
// ============================================================================
// Tuning table checker
// Watches both channels of the tuning table. It keeps its own copy of the
// note frequency table and the fraction gain table. From these it predicts
// the frequency of every accepted lookup and compares each returned item
// against the oldest prediction.
// ============================================================================

module ntft_checker
    import ntft_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_func,
    input  logic signed [C_PITCH_W-1:0] i_pitch,
    input  logic [C_ENTRY_INDEX_W-1:0]  i_entry_index,
    input  logic [C_HZ_W-1:0]           i_entry_hz,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [C_HZ_W-1:0]           i_freq_hz,
    output int                          o_fail_count,
    output int                          o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STEP      = 1 << C_PITCH_FRAC_BITS;
    localparam int          HALF      = STEP / 2;
    localparam logic [63:0] ONE_FIXED = 64'd1 << 62;
    localparam logic [63:0] HZ_MAX    = 64'hFFFF_FFFF;

    typedef struct packed {
        logic signed [C_PITCH_W-1:0] pitch;
        logic [C_HZ_W-1:0]           freq_hz;
    } t_lookup;

    logic [C_HZ_W-1:0]     tuning_hz [0:C_TABLE_DEPTH-1];
    logic [C_FACTOR_W-1:0] frac_gain [0:STEP+HALF-1];
    logic [63:0]           ln2_fixed;
    t_lookup               freq_expected [$];

    function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] pow2_fixed(logic [63:0] num, logic [63:0] den);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        y    = (ln2_fixed / den) * num + ((ln2_fixed % den) * num) / den;
        term = ONE_FIXED;
        sum  = ONE_FIXED;
        for (int k = 1; k < 40 && term != 0; k++) begin
            term = q62_mul(term, y) / 64'(k);
            sum  = sum + term;
        end
        return sum;
    endfunction

    function automatic logic [C_HZ_W-1:0] predict_freq(logic signed [C_PITCH_W-1:0] pitch);
        int          p;
        int          note;
        int          frac;
        logic [63:0] entry;
        logic [63:0] prod;
        p = int'(pitch);
        if (p >= 0) begin
            note = (p + HALF) / STEP;
        end else begin
            note = -((-p + HALF) / STEP);
        end
        if (note < 0) begin
            note = 0;
        end
        if (note > C_TABLE_DEPTH - 1) begin
            note = C_TABLE_DEPTH - 1;
        end
        entry = 64'(tuning_hz[note]);
        frac  = p - note * STEP;
        if (frac == 0) begin
            return entry[C_HZ_W-1:0];
        end
        if (frac < -HALF) begin
            frac = -HALF;
        end
        if (frac > STEP - 1) begin
            frac = STEP - 1;
        end
        prod = (entry * 64'(frac_gain[frac + HALF]) + 64'h8000) >> 16;
        return (prod > HZ_MAX) ? {C_HZ_W{1'b1}} : prod[C_HZ_W-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %0s", $realtime, msg);
        o_fail_count++;
    endtask

    initial begin
        logic [63:0] den;
        logic [63:0] m;
        logic [63:0] v;
        int          oct;
        int          sh;
        o_fail_count = 0;
        o_pending    = 0;
        ln2_fixed    = '0;
        for (int k = 1; k < 62; k++) begin
            ln2_fixed = ln2_fixed + (ONE_FIXED >> k) / 64'(k);
        end
        for (int n = 0; n < C_TABLE_DEPTH; n++) begin
            oct = (n + 3) / 12;
            m   = (pow2_fixed(64'((n + 3) % 12), 64'd12) + 64'd512) >> 10;
            sh  = 42 - oct;
            v   = (64'd440 * m + (64'd1 << (sh - 1))) >> sh;
            tuning_hz[n] = (v > HZ_MAX) ? {C_HZ_W{1'b1}} : v[C_HZ_W-1:0];
        end
        den = 64'd12 << C_PITCH_FRAC_BITS;
        for (int f = -HALF; f < STEP; f++) begin
            if (f >= 0) begin
                v = (pow2_fixed(64'(f), den) + (64'd1 << 45)) >> 46;
            end else begin
                v = (pow2_fixed(den - 64'(-f), den) + (64'd1 << 46)) >> 47;
            end
            frac_gain[f + HALF] = v[C_FACTOR_W-1:0];
        end
    end

    always @(posedge i_clk) begin
        t_lookup oldest;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (freq_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected item freq_hz=%08h", i_freq_hz));
                end else begin
                    oldest = freq_expected.pop_front();
                    if (i_freq_hz !== oldest.freq_hz) begin
                        report_mismatch($sformatf("pitch %0d: freq_hz %08h, predicted %08h",
                                                  oldest.pitch, i_freq_hz, oldest.freq_hz));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_func == C_FUNC_WRITE) begin
                    if (int'(i_entry_index) < C_TABLE_DEPTH) begin
                        tuning_hz[i_entry_index] = i_entry_hz;
                    end
                end else begin
                    freq_expected.push_back('{pitch: i_pitch, freq_hz: predict_freq(i_pitch)});
                end
            end
        end
        o_pending <= freq_expected.size();
    end

endmodule

### verif/testbench.sv
// ============================================================================
// Tuning table testbench
// Drives directed and random write and lookup items into the tuning table,
// with random gaps and stalls on both channels and one long output hold-off.
// A checker beside the block predicts and compares every returned frequency.
// ============================================================================

module testbench
    import ntft_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 1400;
    localparam int STRETCH      = 200;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_OFF     = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 12;
    localparam int NOTE_STEP    = 1 << C_PITCH_FRAC_BITS;
    localparam int PITCH_LOW    = -128;
    localparam int PITCH_HIGH   = 32767;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic                        i_func;
    logic signed [C_PITCH_W-1:0] i_pitch;
    logic [C_ENTRY_INDEX_W-1:0]  i_entry_index;
    logic [C_HZ_W-1:0]           i_entry_hz;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [C_HZ_W-1:0]           o_freq_hz;
    int                          fail_count;
    int                          pending;
    bit                          idle_en;
    bit                          held_off;
    int                          results_seen;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    note_to_frequency_tuning_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_pitch       (i_pitch),
        .i_entry_index (i_entry_index),
        .i_entry_hz    (i_entry_hz),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_freq_hz     (o_freq_hz)
    );

    ntft_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_pitch       (i_pitch),
        .i_entry_index (i_entry_index),
        .i_entry_hz    (i_entry_hz),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_freq_hz     (o_freq_hz),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    task automatic send_item(logic func, logic signed [C_PITCH_W-1:0] pitch,
                             logic [C_ENTRY_INDEX_W-1:0] idx, logic [C_HZ_W-1:0] hz);
        int gap;
        gap = idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_pitch       <= pitch;
        i_entry_index <= idx;
        i_entry_hz    <= hz;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_lookup(int pitch);
        send_item(C_FUNC_LOOKUP, C_PITCH_W'(pitch), C_ENTRY_INDEX_W'($urandom), $urandom);
    endtask

    task automatic send_write(int idx, logic [C_HZ_W-1:0] hz);
        send_item(C_FUNC_WRITE, C_PITCH_W'($urandom), C_ENTRY_INDEX_W'(idx), hz);
    endtask

    function automatic int random_pitch();
        int v;
        case ($urandom_range(0, 3))
            0, 1: v = int'($urandom_range(0, PITCH_HIGH - PITCH_LOW)) + PITCH_LOW;
            2: v = int'($urandom_range(0, C_TABLE_DEPTH - 1)) * NOTE_STEP
                   + (int'($urandom_range(0, 2)) - 1) * (NOTE_STEP / 2)
                   + int'($urandom_range(0, 2)) - 1;
            default: v = $urandom_range(0, 1) ? PITCH_LOW + int'($urandom_range(0, 300))
                                              : PITCH_HIGH - int'($urandom_range(0, 300));
        endcase
        if (v < PITCH_LOW) begin
            v = PITCH_LOW;
        end
        if (v > PITCH_HIGH) begin
            v = PITCH_HIGH;
        end
        return v;
    endfunction

    function automatic logic [C_HZ_W-1:0] random_hz();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return {C_HZ_W{1'b1}};
            2: return {1'b1, 31'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int gap;
        i_out_ready  <= 1'b0;
        held_off     = 1'b0;
        results_seen = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && results_seen == HOLD_AT) begin
                held_off = 1'b1;
                gap      = HOLD_OFF;
            end else begin
                gap = idle_en ? $urandom_range(0, 4) : 0;
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            results_seen++;
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("note_to_frequency_tuning_table verification failed");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_func        <= C_FUNC_WRITE;
        i_pitch       <= '0;
        i_entry_index <= '0;
        i_entry_hz    <= '0;
        idle_en       = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes of the pitch range, exact notes and half-semitone boundaries.
        send_lookup(69 * NOTE_STEP);
        send_lookup(0);
        send_lookup(PITCH_LOW);
        send_lookup(-1);
        send_lookup(NOTE_STEP / 2 - 1);
        send_lookup(NOTE_STEP / 2);
        send_lookup(69 * NOTE_STEP + NOTE_STEP / 2 - 1);
        send_lookup(69 * NOTE_STEP - NOTE_STEP / 2);
        send_lookup(69 * NOTE_STEP + NOTE_STEP / 2);
        send_lookup(PITCH_HIGH);
        send_lookup(127 * NOTE_STEP);
        send_lookup('h5555);
        // Pitches far below the lowest note drive the fraction past the gain table.
        send_lookup(-32768);
        send_lookup(-300);
        // Entry extremes, saturation of the product and lookups after writes.
        send_write(0, '0);
        send_lookup(PITCH_LOW);
        send_lookup(100);
        send_write(C_TABLE_DEPTH - 1, {C_HZ_W{1'b1}});
        send_lookup(PITCH_HIGH);
        send_lookup(127 * NOTE_STEP);
        send_write(69, 32'h8000_0000);
        send_lookup(69 * NOTE_STEP);
        send_lookup(69 * NOTE_STEP + 36);
        send_write(42, 32'h5555_5555);
        send_write(85, 32'hAAAA_AAAA);
        send_lookup(42 * NOTE_STEP + 1);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % STRETCH == 0) begin
                idle_en = ((i / STRETCH) % 3) != 1;
            end
            if ($urandom_range(0, 9) < 3) begin
                send_write(int'($urandom_range(0, (1 << C_ENTRY_INDEX_W) - 1)), random_hz());
            end else begin
                send_lookup(random_pitch());
            end
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("note_to_frequency_tuning_table verification clean");
        end else begin
            $display("note_to_frequency_tuning_table verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/ntft_pkg.sv
hdl/ntft_ram.sv
hdl/ntft_table.sv
hdl/ntft_factor_rom.sv
hdl/note_to_frequency_tuning_table.sv
hdl/ntft_checker.sv
verif/ntft_checker.sv
verif/testbench.sv
